// File: sv/ste_pkg.sv
// ============================================================================
// ste_pkg
// Shared types and constants of the stick-to-pointer emulator.
// ============================================================================
package ste_pkg;

  localparam int unsigned STICK_W  = 16;
  localparam int unsigned BTN_W    = 32;
  localparam int unsigned FT_W     = 16;
  localparam int unsigned DZ_W     = 15;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned PROD_W   = MUL_A_W + GAIN_W;
  localparam int unsigned DELTA_W  = PROD_W - FRAC_W + 1;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 5;

  localparam logic DEF_BUTTONS_EN = 1'b1;
  localparam logic DEF_CURSOR_EN  = 1'b1;
  localparam logic DEF_CLICK_OK   = 1'b1;
  localparam logic [DZ_W-1:0]   DEF_DEAD_ZONE  = 15'd2000;
  localparam logic [GAIN_W-1:0] DEF_SPEED_GAIN = 24'd655;
  localparam logic [BTN_W-1:0]  DEF_CLICK_MASK = 32'd0;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_BUTTONS_EN = 3'd0,
    REG_CURSOR_EN  = 3'd1,
    REG_CLICK_OK   = 3'd2,
    REG_DEAD_ZONE  = 3'd3,
    REG_SPEED_GAIN = 3'd4,
    REG_CLICK_MASK = 3'd5
  } ste_reg_t;

  typedef struct packed {
    logic              buttons_en;
    logic              cursor_en;
    logic              click_ok;
    logic [DZ_W-1:0]   dead_zone;
    logic [GAIN_W-1:0] speed_gain;
    logic [BTN_W-1:0]  click_mask;
  } ste_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MX1,
    ST_MX2,
    ST_MY1,
    ST_MY2,
    ST_ACCX,
    ST_ACCY,
    ST_EMIT
  } ste_state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_MAG_X,
    MUL_MAG_Y,
    MUL_GAIN
  } ste_mul_t;

  typedef struct packed {
    logic     load;
    ste_mul_t mul_sel;
    logic     cap_dx;
    logic     cap_dy;
    logic     acc_x;
    logic     acc_y;
    logic     emit;
  } ste_cmd_t;

  typedef struct packed {
    logic out_free;
  } ste_status_t;

endpackage

// File: sv/ste_if.sv
// ============================================================================
// ste_if
// Valid/ready channels for stick samples and pointer results.
// ============================================================================
interface ste_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ste_pkg::STICK_W-1:0]  stick_x;
  logic signed [ste_pkg::STICK_W-1:0]  stick_y;
  logic        [ste_pkg::BTN_W-1:0]    button_word;
  logic        [ste_pkg::FT_W-1:0]     frame_time;

  modport source (output valid, stick_x, stick_y, button_word, frame_time, input ready);
  modport sink   (input valid, stick_x, stick_y, button_word, frame_time, output ready);
endinterface

interface ste_out_if;
  logic                                valid;
  logic                                ready;
  logic                                click_down;
  logic                                click_up;
  logic                                move_valid;
  logic signed [ste_pkg::STICK_W-1:0]  move_x;
  logic signed [ste_pkg::STICK_W-1:0]  move_y;

  modport source (output valid, click_down, click_up, move_valid, move_x, move_y,
                  input ready);
  modport sink   (input valid, click_down, click_up, move_valid, move_x, move_y,
                  output ready);
endinterface

// File: sv/ste_cfg_regs.sv
// ============================================================================
// ste_cfg_regs
// APB register file holding the emulator configuration.
// ============================================================================
module ste_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ste_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [ste_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [ste_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output ste_pkg::ste_cfg_t            cfg
);

  ste_pkg::ste_cfg_t cfg_r;
  ste_pkg::ste_cfg_t cfg_nxt;
  logic              wr_en;
  logic [2:0]        idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        ste_pkg::REG_BUTTONS_EN: cfg_nxt.buttons_en = cfg_pwdata[0];
        ste_pkg::REG_CURSOR_EN:  cfg_nxt.cursor_en  = cfg_pwdata[0];
        ste_pkg::REG_CLICK_OK:   cfg_nxt.click_ok   = cfg_pwdata[0];
        ste_pkg::REG_DEAD_ZONE:  cfg_nxt.dead_zone  = cfg_pwdata[ste_pkg::DZ_W-1:0];
        ste_pkg::REG_SPEED_GAIN: cfg_nxt.speed_gain = cfg_pwdata[ste_pkg::GAIN_W-1:0];
        ste_pkg::REG_CLICK_MASK: cfg_nxt.click_mask = cfg_pwdata[ste_pkg::BTN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buttons_en <= ste_pkg::DEF_BUTTONS_EN;
      cfg_r.cursor_en  <= ste_pkg::DEF_CURSOR_EN;
      cfg_r.click_ok   <= ste_pkg::DEF_CLICK_OK;
      cfg_r.dead_zone  <= ste_pkg::DEF_DEAD_ZONE;
      cfg_r.speed_gain <= ste_pkg::DEF_SPEED_GAIN;
      cfg_r.click_mask <= ste_pkg::DEF_CLICK_MASK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      ste_pkg::REG_BUTTONS_EN: cfg_prdata[0] = cfg_r.buttons_en;
      ste_pkg::REG_CURSOR_EN:  cfg_prdata[0] = cfg_r.cursor_en;
      ste_pkg::REG_CLICK_OK:   cfg_prdata[0] = cfg_r.click_ok;
      ste_pkg::REG_DEAD_ZONE:  cfg_prdata[ste_pkg::DZ_W-1:0] = cfg_r.dead_zone;
      ste_pkg::REG_SPEED_GAIN: cfg_prdata[ste_pkg::GAIN_W-1:0] = cfg_r.speed_gain;
      ste_pkg::REG_CLICK_MASK: cfg_prdata = cfg_r.click_mask;
      default: ;
    endcase
  end

endmodule

// File: sv/ste_ctrl.sv
// ============================================================================
// ste_ctrl
// Sequencer stepping one sample through the shared multiplier and accumulators.
// ============================================================================
module ste_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ste_pkg::ste_status_t  status,
  output ste_pkg::ste_cmd_t     cmd
);

  ste_pkg::ste_state_t state_r;
  ste_pkg::ste_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ste_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = ste_pkg::MUL_NONE;
    unique case (state_r)
      ste_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ste_pkg::ST_MX1;
        end
      end
      ste_pkg::ST_MX1: begin
        cmd.mul_sel = ste_pkg::MUL_MAG_X;
        state_nxt   = ste_pkg::ST_MX2;
      end
      ste_pkg::ST_MX2: begin
        cmd.mul_sel = ste_pkg::MUL_GAIN;
        state_nxt   = ste_pkg::ST_MY1;
      end
      ste_pkg::ST_MY1: begin
        cmd.cap_dx  = 1'b1;
        cmd.mul_sel = ste_pkg::MUL_MAG_Y;
        state_nxt   = ste_pkg::ST_MY2;
      end
      ste_pkg::ST_MY2: begin
        cmd.mul_sel = ste_pkg::MUL_GAIN;
        state_nxt   = ste_pkg::ST_ACCX;
      end
      ste_pkg::ST_ACCX: begin
        cmd.cap_dy = 1'b1;
        cmd.acc_x  = 1'b1;
        state_nxt  = ste_pkg::ST_ACCY;
      end
      ste_pkg::ST_ACCY: begin
        cmd.acc_y = 1'b1;
        state_nxt = ste_pkg::ST_EMIT;
      end
      ste_pkg::ST_EMIT: begin
        // hold until the result register can take the transaction
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ste_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ste_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/ste_datapath.sv
// ============================================================================
// ste_datapath
// Dead zone, shared multiplier, Q32.16 accumulators, click logic and result
// register.
// ============================================================================
module ste_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ste_pkg::ste_cfg_t                  cfg,
  input  ste_pkg::ste_cmd_t                  cmd,
  output ste_pkg::ste_status_t               status,
  input  logic signed [ste_pkg::STICK_W-1:0] stick_x,
  input  logic signed [ste_pkg::STICK_W-1:0] stick_y,
  input  logic        [ste_pkg::BTN_W-1:0]   button_word,
  input  logic        [ste_pkg::FT_W-1:0]    frame_time,
  ste_out_if.source                          out_chan
);

  localparam int unsigned ACC_W   = ste_pkg::ACC_W;
  localparam int unsigned SUM_W   = ACC_W + 1;
  localparam int unsigned DELTA_W = ste_pkg::DELTA_W;
  localparam int unsigned SW      = ste_pkg::STICK_W;
  localparam int unsigned WHOLE_W = ACC_W - ste_pkg::FRAC_W;
  localparam logic signed [SUM_W-1:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX;
  localparam logic [ACC_W-1:0] ONE_Q16 = ACC_W'(1) << ste_pkg::FRAC_W;
  localparam logic [WHOLE_W-1:0] POS_MAX = WHOLE_W'((1 << (SW-1)) - 1);
  localparam logic [WHOLE_W-1:0] NEG_MAX = WHOLE_W'(1 << (SW-1));

  // Sample registers
  logic [SW-1:0]                   magx_r, magy_r;
  logic                            negx_r, negy_r;
  logic                            active_r;
  logic [ste_pkg::BTN_W-1:0]       bw_r;
  logic [ste_pkg::FT_W-1:0]        ft_r;
  logic [ste_pkg::PROD_W-1:0]      prod_r;
  logic signed [DELTA_W-1:0]       dx_r, dy_r;

  // State
  logic signed [ACC_W-1:0]         accx_r, accx_nxt;
  logic signed [ACC_W-1:0]         accy_r, accy_nxt;
  logic [ste_pkg::BTN_W-1:0]       prev_r, prev_nxt;

  // Result register
  logic                            out_valid_r;
  logic                            down_r, up_r, mvalid_r;
  logic signed [SW-1:0]            mx_r, my_r;

  logic [SW-1:0]                   in_magx, in_magy;
  logic [ste_pkg::MUL_A_W-1:0]     mul_a;
  logic [ste_pkg::GAIN_W-1:0]      mul_b;
  logic [DELTA_W-1:0]              dmag;
  logic signed [DELTA_W-1:0]       dsigned;
  logic signed [ACC_W-1:0]         acc_sel, acc_new;
  logic signed [DELTA_W-1:0]       d_sel;
  logic signed [SUM_W-1:0]         sum;
  logic [ACC_W-1:0]                magax, magay;
  logic                            over;
  logic signed [SW-1:0]            wx, wy;
  logic signed [ACC_W-1:0]         remx, remy;
  logic                            was, now, down, up;

  function automatic logic [SW-1:0] abs16(input logic signed [SW-1:0] v);
    abs16 = v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] a);
    abs_acc = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
  endfunction

  // Whole part toward zero, saturated to the move width
  function automatic logic signed [SW-1:0] whole_sat(input logic signed [ACC_W-1:0] a,
                                                     input logic [ACC_W-1:0] mag);
    logic [WHOLE_W-1:0] whole;
    whole = mag[ACC_W-1:ste_pkg::FRAC_W];
    if (a[ACC_W-1]) begin
      whole_sat = (whole > NEG_MAX) ? SW'(NEG_MAX) : SW'(-whole);
    end else begin
      whole_sat = (whole > POS_MAX) ? SW'(POS_MAX) : SW'(whole);
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] frac_keep(input logic signed [ACC_W-1:0] a,
                                                        input logic [ACC_W-1:0] mag);
    logic [ACC_W-1:0] frac;
    frac = {{WHOLE_W{1'b0}}, mag[ste_pkg::FRAC_W-1:0]};
    frac_keep = a[ACC_W-1] ? -$signed(frac) : $signed(frac);
  endfunction

  assign in_magx = abs16(stick_x);
  assign in_magy = abs16(stick_y);

  // Dead zone taken off at load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      magx_r   <= (in_magx > SW'(cfg.dead_zone)) ? in_magx - SW'(cfg.dead_zone) : '0;
      magy_r   <= (in_magy > SW'(cfg.dead_zone)) ? in_magy - SW'(cfg.dead_zone) : '0;
      negx_r   <= stick_x[SW-1];
      negy_r   <= ~stick_y[SW-1];
      active_r <= cfg.cursor_en &&
                  ((in_magx > SW'(cfg.dead_zone)) || (in_magy > SW'(cfg.dead_zone)));
      bw_r     <= button_word;
      ft_r     <= frame_time;
    end
  end

  // Shared multiplier: magnitude times frame time, then times gain
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      ste_pkg::MUL_MAG_X: begin
        mul_a = ste_pkg::MUL_A_W'(magx_r);
        mul_b = ste_pkg::GAIN_W'(ft_r);
      end
      ste_pkg::MUL_MAG_Y: begin
        mul_a = ste_pkg::MUL_A_W'(magy_r);
        mul_b = ste_pkg::GAIN_W'(ft_r);
      end
      ste_pkg::MUL_GAIN: begin
        mul_a = prod_r[ste_pkg::MUL_A_W-1:0];
        mul_b = cfg.speed_gain;
      end
      ste_pkg::MUL_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != ste_pkg::MUL_NONE) begin
      prod_r <= ste_pkg::PROD_W'(mul_a) * ste_pkg::PROD_W'(mul_b);
    end
  end

  assign dmag    = {1'b0, prod_r[ste_pkg::PROD_W-1:ste_pkg::FRAC_W]};
  assign dsigned = (cmd.cap_dx ? negx_r : negy_r) ? -$signed(dmag) : $signed(dmag);

  always_ff @(posedge clk) begin
    if (cmd.cap_dx) dx_r <= dsigned;
    if (cmd.cap_dy) dy_r <= dsigned;
  end

  // Saturating accumulate, one axis per cycle
  assign acc_sel = cmd.acc_x ? accx_r : accy_r;
  assign d_sel   = cmd.acc_x ? dx_r : dy_r;
  assign sum     = SUM_W'(acc_sel) + SUM_W'(d_sel);

  always_comb begin
    priority if (sum > ACC_MAX) begin
      acc_new = ACC_W'(ACC_MAX);
    end else if (sum < ACC_MIN) begin
      acc_new = ACC_W'(ACC_MIN);
    end else begin
      acc_new = ACC_W'(sum);
    end
  end

  // Move emission
  assign magax = abs_acc(accx_r);
  assign magay = abs_acc(accy_r);
  assign over  = active_r && ((magax > ONE_Q16) || (magay > ONE_Q16));
  assign wx    = whole_sat(accx_r, magax);
  assign wy    = whole_sat(accy_r, magay);
  assign remx  = frac_keep(accx_r, magax);
  assign remy  = frac_keep(accy_r, magay);

  // Click edges
  assign was = |(prev_r & cfg.click_mask);
  assign now = |(bw_r & cfg.click_mask);

  always_comb begin
    down     = 1'b0;
    up       = 1'b0;
    prev_nxt = prev_r;
    if (cfg.buttons_en) begin
      if (!cfg.click_ok) begin
        up       = was;
        prev_nxt = '0;
      end else begin
        down     = now && !was;
        up       = !now && was;
        prev_nxt = bw_r;
      end
    end
  end

  always_comb begin
    accx_nxt = accx_r;
    accy_nxt = accy_r;
    if (cmd.acc_x && active_r) accx_nxt = acc_new;
    if (cmd.acc_y && active_r) accy_nxt = acc_new;
    if (cmd.emit && over) begin
      accx_nxt = remx;
      accy_nxt = remy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accx_r <= '0;
      accy_r <= '0;
      prev_r <= '0;
    end else begin
      accx_r <= accx_nxt;
      accy_r <= accy_nxt;
      if (cmd.emit) prev_r <= prev_nxt;
    end
  end

  assign status.out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      down_r   <= down;
      up_r     <= up;
      mvalid_r <= over;
      mx_r     <= over ? wx : '0;
      my_r     <= over ? wy : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.click_down = down_r;
  assign out_chan.click_up   = up_r;
  assign out_chan.move_valid = mvalid_r;
  assign out_chan.move_x     = mx_r;
  assign out_chan.move_y     = my_r;

endmodule

// File: sv/stick_to_pointer_emulator.sv
// ============================================================================
// stick_to_pointer_emulator
// Gamepad stick and buttons to emulated pointer moves and left clicks.
// ============================================================================
// Sequence: a taken sample steps through MX1, MX2, MY1, MY2, ACCX, ACCY and EMIT;
//   EMIT waits while the previous result still waits for the sink.
// The next sample is taken only once the last one has left EMIT; the single shared
//   32x24 multiplier is used four times per sample (two products per axis).
// Reset (rst_n, synchronous, active low): configuration to defaults,
//   accumulators and remembered buttons to zero, no result pending.
module stick_to_pointer_emulator (
  input  logic                        clk,
  input  logic                        rst_n,
  ste_in_if.sink                      in_chan,
  ste_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ste_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [ste_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [ste_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  ste_pkg::ste_cfg_t    cfg;
  ste_pkg::ste_cmd_t    cmd;
  ste_pkg::ste_status_t status;
  logic                 in_ready;

  // Configuration registers; the user writes them only while no sample is in flight (not enforced here)
  ste_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Sequencer: take a sample, run the multiply and accumulate steps, emit
  ste_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The result register frees the input side: a new sample is taken while a
  // finished result waits for the sink.
  assign in_chan.ready = in_ready;

  // Arithmetic, click edges and the result register
  ste_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .stick_x     (in_chan.stick_x),
    .stick_y     (in_chan.stick_y),
    .button_word (in_chan.button_word),
    .frame_time  (in_chan.frame_time),
    .out_chan    (out_chan)
  );

endmodule

// File: bench/pointer_checker.sv
// ============================================================================
// pointer_checker
// Watches the sample and result channels and the register port of the
// stick-to-pointer emulator. Keeps its own copy of the registers, the held
// buttons and both accumulators. Predicts one pointer result per accepted
// sample and compares it with the results that the block hands out, in order.
// ============================================================================
module pointer_checker
  import ste_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ste_in_if                 in_mon,
  ste_out_if                out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output int                mismatches,
  output int                outstanding,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                      click_down;
    logic                      click_up;
    logic                      move_valid;
    logic signed [STICK_W-1:0] move_x;
    logic signed [STICK_W-1:0] move_y;
  } pointer_t;

  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ONE_PX  = 64'sd65536;

  ste_cfg_t         regs;
  logic [BTN_W-1:0] held_buttons;
  longint           acc_x;
  longint           acc_y;
  pointer_t         pointer_q[$];

  function automatic longint abs64(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  // take the dead zone off toward zero; inside it the deflection is zero
  function automatic longint past_dead_zone(input logic signed [STICK_W-1:0] d);
    longint v;
    longint dz;
    v  = d;
    dz = regs.dead_zone;
    if (abs64(v) < dz) return 0;
    return (v > 0) ? v - dz : v + dz;
  endfunction

  // |v| * frame_time * gain, drop 16 fraction bits, then put the sign back
  function automatic longint scaled_step(input longint v, input logic [FT_W-1:0] ft);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = abs64(v);
    prod = (mag * ft * regs.speed_gain) >> FRAC_W;
    return (v < 0) ? -$signed(prod) : $signed(prod);
  endfunction

  function automatic longint clamp_acc(input longint a);
    if (a > ACC_MAX) return ACC_MAX;
    if (a < -ACC_MAX) return -ACC_MAX;
    return a;
  endfunction

  function automatic logic signed [STICK_W-1:0] whole_part(input longint a);
    longint w;
    w = abs64(a) >>> FRAC_W;
    if (a < 0) w = -w;
    if (w > 32767) w = 32767;
    else if (w < -32768) w = -32768;
    return w[STICK_W-1:0];
  endfunction

  function automatic longint frac_part(input longint a);
    longint f;
    f = abs64(a) & 64'hFFFF;
    return (a < 0) ? -f : f;
  endfunction

  function automatic pointer_t predict_pointer(input logic signed [STICK_W-1:0] sx,
                                               input logic signed [STICK_W-1:0] sy,
                                               input logic [BTN_W-1:0] bw,
                                               input logic [FT_W-1:0] ft);
    pointer_t r;
    logic     was;
    logic     now;
    longint   vx;
    longint   vy;
    r = '0;
    if (regs.buttons_en) begin
      was = |(held_buttons & regs.click_mask);
      if (!regs.click_ok) begin
        r.click_up   = was;
        held_buttons = '0;
      end else begin
        now          = |(bw & regs.click_mask);
        r.click_down = now && !was;
        r.click_up   = !now && was;
        held_buttons = bw;
      end
    end
    if (regs.cursor_en) begin
      vx = past_dead_zone(sx);
      vy = past_dead_zone(sy);
      if (vx != 0 || vy != 0) begin
        acc_x = clamp_acc(acc_x + scaled_step(vx, ft));
        acc_y = clamp_acc(acc_y - scaled_step(vy, ft));
        if (abs64(acc_x) > ONE_PX || abs64(acc_y) > ONE_PX) begin
          r.move_valid = 1'b1;
          r.move_x     = whole_part(acc_x);
          r.move_y     = whole_part(acc_y);
          acc_x        = frac_part(acc_x);
          acc_y        = frac_part(acc_y);
        end
      end
    end
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("checker: %s", msg);
  endtask

  always @(posedge clk) begin
    pointer_t want;
    pointer_t got;
    if (!rst_n) begin
      regs.buttons_en = DEF_BUTTONS_EN;
      regs.cursor_en  = DEF_CURSOR_EN;
      regs.click_ok   = DEF_CLICK_OK;
      regs.dead_zone  = DEF_DEAD_ZONE;
      regs.speed_gain = DEF_SPEED_GAIN;
      regs.click_mask = DEF_CLICK_MASK;
      held_buttons    = '0;
      acc_x           = 0;
      acc_y           = 0;
      pointer_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (ste_reg_t'(cfg_paddr[APB_AW-1:2]))
          REG_BUTTONS_EN: regs.buttons_en = cfg_pwdata[0];
          REG_CURSOR_EN:  regs.cursor_en  = cfg_pwdata[0];
          REG_CLICK_OK:   regs.click_ok   = cfg_pwdata[0];
          REG_DEAD_ZONE:  regs.dead_zone  = cfg_pwdata[DZ_W-1:0];
          REG_SPEED_GAIN: regs.speed_gain = cfg_pwdata[GAIN_W-1:0];
          REG_CLICK_MASK: regs.click_mask = cfg_pwdata[BTN_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.click_down = out_mon.click_down;
        got.click_up   = out_mon.click_up;
        got.move_valid = out_mon.move_valid;
        got.move_x     = out_mon.move_x;
        got.move_y     = out_mon.move_y;
        results_seen++;
        if (pointer_q.size() == 0) begin
          flag($sformatf("result with nothing pending: down=%b up=%b mv=%b x=%0d y=%0d",
                         got.click_down, got.click_up, got.move_valid, got.move_x, got.move_y));
        end else begin
          want = pointer_q.pop_front();
          if (got.click_down !== want.click_down || got.click_up !== want.click_up ||
              got.move_valid !== want.move_valid || got.move_x !== want.move_x ||
              got.move_y !== want.move_y) begin
            flag($sformatf("result %0d: want down=%b up=%b mv=%b x=%0d y=%0d, got down=%b up=%b mv=%b x=%0d y=%0d",
                           results_seen, want.click_down, want.click_up, want.move_valid,
                           want.move_x, want.move_y, got.click_down, got.click_up,
                           got.move_valid, got.move_x, got.move_y));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pointer_q.push_back(predict_pointer(in_mon.stick_x, in_mon.stick_y,
                                            in_mon.button_word, in_mon.frame_time));
      end
    end
    outstanding = pointer_q.size();
  end

endmodule

// File: bench/tb.sv
// ============================================================================
// tb
// Top of the stick-to-pointer emulator bench.
// Drives stick samples and register writes, lets the checker predict and
// compare every pointer result, and prints the verdict. A short directed part
// covers the move threshold, the dead zone edge, field extremes, click edges,
// click blocking and the disable bits; random rounds under several register
// settings follow, both channel sides stalling at random over the first two thirds.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;

  localparam int ROUNDS      = 8;
  localparam int PER_ROUND   = 200;
  localparam int TOTAL_RAND  = ROUNDS * PER_ROUND;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int               send_idle_pct;
  int               recv_idle_pct;
  int               dz_now;
  int               samples_sent;
  int               settings_applied;
  int               cycle_count;
  logic [BTN_W-1:0] last_buttons;

  int mismatches;
  int outstanding;
  int results_seen;

  ste_in_if  in_chan ();
  ste_out_if out_chan ();

  stick_to_pointer_emulator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pointer_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side: drop ready at random, as the current idle share says.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // One sample transaction. Entered and left right after a rising edge; valid
  // stays high into the next call unless that call idles first, so valid never
  // gets two assignments in one time step.
  task automatic send_sample(input logic signed [STICK_W-1:0] sx,
                             input logic signed [STICK_W-1:0] sy,
                             input logic [BTN_W-1:0] bw,
                             input logic [FT_W-1:0] ft);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.stick_x     <= sx;
    in_chan.stick_y     <= sy;
    in_chan.button_word <= bw;
    in_chan.frame_time  <= ft;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back. One
  // result per sample, so an empty store means the block is idle.
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Setup phase, access phase, then psel low before returning, so back-to-back
  // writes never assign psel twice in one step.
  task automatic write_reg(input ste_reg_t idx, input logic [APB_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write all six registers; call only after settle().
  task automatic apply_setting(input bit btn_en, input bit cur_en, input bit click_ok,
                               input logic [DZ_W-1:0] dz, input logic [GAIN_W-1:0] gain,
                               input logic [BTN_W-1:0] mask);
    write_reg(REG_BUTTONS_EN, APB_DW'(btn_en));
    write_reg(REG_CURSOR_EN,  APB_DW'(cur_en));
    write_reg(REG_CLICK_OK,   APB_DW'(click_ok));
    write_reg(REG_DEAD_ZONE,  APB_DW'(dz));
    write_reg(REG_SPEED_GAIN, APB_DW'(gain));
    write_reg(REG_CLICK_MASK, mask);
    dz_now = dz;
    settings_applied++;
  endtask

  // Axis value: rail values, values hugging the dead zone edge, center, or
  // anything at all.
  function automatic logic signed [STICK_W-1:0] pick_axis();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1: v = dz_now + int'($urandom_range(0, 2)) - 1;
      2: v = -(dz_now + int'($urandom_range(0, 2)) - 1);
      3: v = 0;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[STICK_W-1:0];
  endfunction

  // Button word: mostly hold or flip one bit of the last word so that press
  // and release edges come often; sometimes a fresh random word.
  function automatic logic [BTN_W-1:0] pick_buttons();
    case ($urandom_range(0, 5))
      0: last_buttons = $urandom();
      1, 2: last_buttons = last_buttons ^ (32'h1 << $urandom_range(0, 31));
      3: last_buttons = last_buttons ^ (32'h1 << $urandom_range(0, 3));
      4: last_buttons = $urandom_range(0, 1) ? '0 : '1;
      default: ;
    endcase
    return last_buttons;
  endfunction

  // Frame time: mostly a plausible frame period, sometimes the extremes.
  function automatic logic [FT_W-1:0] pick_frame_time();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return FT_W'($urandom_range(0, 65535));
      default: return FT_W'($urandom_range(500, 2200));
    endcase
  endfunction

  initial begin
    int r;
    int k;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.stick_x     <= '0;
    in_chan.stick_y     <= '0;
    in_chan.button_word <= '0;
    in_chan.frame_time  <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    send_idle_pct    = 32;
    recv_idle_pct    = 71;
    dz_now           = DEF_DEAD_ZONE;
    samples_sent     = 0;
    settings_applied = 0;
    last_buttons     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Move threshold: with zero dead zone and gain 1.0 a step is |v|*ft.
    // Exactly one pixel stays in the accumulator; one LSB more emits.
    apply_setting(1'b1, 1'b1, 1'b1, 15'd0, 24'h01_0000, 32'h0000_0001);
    send_sample(16'sd2, 16'sd0, 32'h0, 16'd32768);
    send_sample(16'sd1, 16'sd0, 32'h0, 16'd1);
    send_sample(16'sd0, 16'sd2, 32'h0, 16'd32768);
    send_sample(16'sd0, 16'sd1, 32'h0, 16'd1);

    // Reset-value registers: rails, inside, on and just past the dead zone.
    settle();
    apply_setting(DEF_BUTTONS_EN, DEF_CURSOR_EN, DEF_CLICK_OK, DEF_DEAD_ZONE,
                  DEF_SPEED_GAIN, DEF_CLICK_MASK);
    send_sample(16'sd0, 16'sd0, 32'h0, 16'h0000);
    send_sample(16'sd32767, -16'sd32768, 32'hFFFF_FFFF, 16'hFFFF);
    send_sample(-16'sd32768, 16'sd32767, 32'h0, 16'hFFFF);
    send_sample(16'sd1999, -16'sd1999, 32'h0, 16'hFFFF);
    send_sample(16'sd2000, -16'sd2000, 32'h0, 16'hFFFF);
    send_sample(16'sd2001, 16'sd0, 32'h0, 16'hFFFF);

    // Full gain: saturated moves both ways, then press and release edges.
    settle();
    apply_setting(1'b1, 1'b1, 1'b1, 15'd0, 24'hFF_FFFF, 32'h0000_0001);
    send_sample(16'sd32767, 16'sd32767, 32'h1, 16'hFFFF);
    send_sample(-16'sd32768, -16'sd32768, 32'h1, 16'hFFFF);
    send_sample(16'sd0, 16'sd0, 32'h0, 16'hFFFF);
    send_sample(16'sd0, 16'sd0, 32'h3, 16'h0000);
    send_sample(16'sd1, 16'sd0, 32'h2, 16'h0000);
    send_sample(16'sd0, 16'sd0, 32'h1, 16'h0000);

    // Click blocked while the held word has the masked bit: one forced release.
    settle();
    apply_setting(1'b1, 1'b1, 1'b0, 15'd0, 24'hFF_FFFF, 32'h0000_0001);
    send_sample(16'sd0, 16'sd0, 32'h1, 16'h0000);
    send_sample(16'sd0, 16'sd0, 32'h1, 16'h0000);

    // Buttons and cursor both off: empty results, held word left alone.
    settle();
    apply_setting(1'b0, 1'b0, 1'b1, DEF_DEAD_ZONE, DEF_SPEED_GAIN, 32'h0000_0001);
    send_sample(16'sd32767, 16'sd32767, 32'h1, 16'hFFFF);
    send_sample(-16'sd32768, 16'sd0, 32'h0, 16'hFFFF);

    // Random rounds, each under its own register setting. Idle shares change
    // by thirds of the random part: receiver-heavy, sender-heavy, none.
    for (r = 0; r < ROUNDS; r++) begin
      settle();
      case (r)
        0: apply_setting(1'b1, 1'b1, 1'b1, DEF_DEAD_ZONE, DEF_SPEED_GAIN,
                         32'h1 << $urandom_range(0, 31));
        1: apply_setting(1'b1, 1'b1, 1'b1, 15'd0, 24'hFF_FFFF, 32'hFFFF_FFFF);
        2: apply_setting(1'b1, 1'b1, 1'b1, 15'h7FFF, 24'hFF_FFFF, $urandom());
        3: apply_setting(1'b1, 1'b1, 1'b1, DZ_W'($urandom_range(0, 4000)), 24'd0,
                         $urandom());
        default: apply_setting($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                               $urandom_range(0, 2) != 0, DZ_W'($urandom_range(0, 4000)),
                               GAIN_W'($urandom_range(0, 24'h0F_FFFF)),
                               $urandom() & $urandom());
      endcase
      for (k = 0; k < PER_ROUND; k++) begin
        if (r * PER_ROUND + k < TOTAL_RAND / 3) begin
          send_idle_pct = 32;
          recv_idle_pct = 71;
        end else if (r * PER_ROUND + k < 2 * TOTAL_RAND / 3) begin
          send_idle_pct = 71;
          recv_idle_pct = 32;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_sample(pick_axis(), pick_axis(), pick_buttons(), pick_frame_time());
      end
    end

    // Hold for the block's latency after the last result, so a stray extra
    // result still gets caught.
    settle();
    repeat (16) @(posedge clk);

    $display("tb: %0d samples over %0d register settings, %0d pointer results compared",
             samples_sent, settings_applied, results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches, %0d results missing", mismatches, outstanding);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
